### rtl/core/three_channel_zone_alarm_monitor_macros.svh
// ----------------------------------------------------------------------------
// Zone alarm monitor assertion macros
// Shared assertion shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef THREE_CHANNEL_ZONE_ALARM_MONITOR_MACROS_SVH
`define THREE_CHANNEL_ZONE_ALARM_MONITOR_MACROS_SVH

// clocked assertion, disabled during reset
`define TCZAM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that holds whenever an output word is presented
`define TCZAM_ASSERT_OUT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) m_tvalid |-> (cond)) \
        else $error(msg);

`endif

### rtl/core/tczam_pkg.sv
// ----------------------------------------------------------------------------
// Zone alarm monitor package
// Shared widths, register indexes, codes and the queue entry type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tczam_pkg;

    localparam int DATA_W   = 32;
    localparam int MARGIN_W = 16;
    localparam int PROD_W   = 48;
    localparam int WIDE_W   = 34;
    localparam int DEV_W    = 33;
    localparam int CH_W     = 2;
    localparam int NUM_CH   = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN    = 3'd6;

    localparam logic [CH_W-1:0] CH_TEMP  = 2'd0;
    localparam logic [CH_W-1:0] CH_HUM   = 2'd1;
    localparam logic [CH_W-1:0] CH_LIGHT = 2'd2;

    localparam logic [1:0] ST_GOOD   = 2'd0;
    localparam logic [1:0] ST_YELLOW = 2'd1;
    localparam logic [1:0] ST_RED    = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0]          ch;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] gmin;
        logic signed [DATA_W-1:0] gmax;
        logic signed [PROD_W-1:0] pmin;
        logic signed [PROD_W-1:0] pmax;
        logic                     button;
    } item_t;

    typedef struct packed {
        logic [CH_W-1:0]         ch;
        logic [1:0]              status;
        logic signed [DEV_W-1:0] deviation;
        logic                    led;
        logic                    buzzer;
        logic [NUM_CH-1:0]       yellow;
        logic [NUM_CH-1:0]       red;
        logic [NUM_CH-1:0]       armed;
    } result_t;

endpackage

### rtl/core/tczam_front.sv
// ----------------------------------------------------------------------------
// Zone alarm monitor front end
// Holds the band registers, rotates the channel, selects the reading and
// bounds and forms the margin products for the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tczam_front
    import tczam_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] temp_value,
    input  logic signed [DATA_W-1:0] hum_value,
    input  logic signed [DATA_W-1:0] light_value,
    input  logic                     button_pressed,
    input  logic                     queue_full,
    output logic                     push,
    output item_t                    push_item
);

    logic signed [DATA_W-1:0] gmin_reg [NUM_CH];
    logic signed [DATA_W-1:0] gmax_reg [NUM_CH];
    logic [MARGIN_W-1:0]      margin_reg;
    logic [CH_W-1:0]          ch_idx_reg;
    logic [CH_W-1:0]          ch_idx_next;

    logic signed [DATA_W-1:0] sel_value;
    logic signed [DATA_W-1:0] sel_gmin;
    logic signed [DATA_W-1:0] sel_gmax;
    logic signed [PROD_W:0]   prod_min;
    logic signed [PROD_W:0]   prod_max;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                gmin_reg[i] <= '0;
                gmax_reg[i] <= '0;
            end
            margin_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TEMP_MIN:  gmin_reg[0] <= cfg_data;
                REG_TEMP_MAX:  gmax_reg[0] <= cfg_data;
                REG_HUM_MIN:   gmin_reg[1] <= cfg_data;
                REG_HUM_MAX:   gmax_reg[1] <= cfg_data;
                REG_LIGHT_MIN: gmin_reg[2] <= cfg_data;
                REG_LIGHT_MAX: gmax_reg[2] <= cfg_data;
                REG_MARGIN:    margin_reg  <= cfg_data[MARGIN_W-1:0];
                default:       ;
            endcase
        end
    end

    // index advances before use; light (and the unused code) wraps to temp
    assign ch_idx_next = (ch_idx_reg == CH_LIGHT || ch_idx_reg > CH_LIGHT) ?
                         CH_TEMP : ch_idx_reg + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ch_idx_reg <= CH_TEMP;
        else if (push)
            ch_idx_reg <= ch_idx_next;
    end

    always_comb
    begin
        case (ch_idx_next)
            CH_TEMP:
            begin
                sel_value = temp_value;
                sel_gmin  = gmin_reg[0];
                sel_gmax  = gmax_reg[0];
            end
            CH_HUM:
            begin
                sel_value = hum_value;
                sel_gmin  = gmin_reg[1];
                sel_gmax  = gmax_reg[1];
            end
            default:
            begin
                sel_value = light_value;
                sel_gmin  = gmin_reg[2];
                sel_gmax  = gmax_reg[2];
            end
        endcase
    end

    assign prod_min = sel_gmin * $signed({1'b0, margin_reg});
    assign prod_max = sel_gmax * $signed({1'b0, margin_reg});

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    assign push_item.ch     = ch_idx_next;
    assign push_item.value  = sel_value;
    assign push_item.gmin   = sel_gmin;
    assign push_item.gmax   = sel_gmax;
    assign push_item.pmin   = prod_min[PROD_W-1:0];
    assign push_item.pmax   = prod_max[PROD_W-1:0];
    assign push_item.button = button_pressed;

endmodule

### rtl/core/tczam_queue.sv
// ----------------------------------------------------------------------------
// Zone alarm monitor queue
// Small register FIFO between the front end and the classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tczam_queue
    import tczam_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output logic  full,
    output logic  not_empty,
    output item_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 :
                              wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 :
                              rd_ptr_reg + PTR_W'(1);
        end
    end

endmodule

### rtl/core/tczam_back.sv
// ----------------------------------------------------------------------------
// Zone alarm monitor back end
// Builds the yellow bounds, classifies the reading, updates the alarm
// flags, LED and buzzer, and holds the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tczam_back
    import tczam_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    input  item_t   head,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_word
);

    logic [NUM_CH-1:0] yellow_reg, yellow_next;
    logic [NUM_CH-1:0] red_reg, red_next;
    logic [NUM_CH-1:0] armed_reg, armed_next;
    logic              led_reg, led_next;
    logic              buzzer_reg, buzzer_next;
    logic              out_valid_reg;
    result_t           out_word_reg;

    logic signed [PROD_W-1:0] sh_min, sh_max;
    logic signed [WIDE_W-1:0] v, gmin, gmax, ymin, ymax, dev;
    logic [1:0]               status;
    logic [NUM_CH-1:0]        bit_sel;

    // arithmetic shift floors toward minus infinity
    assign sh_min = head.pmin >>> MARGIN_W;
    assign sh_max = head.pmax >>> MARGIN_W;

    assign v    = WIDE_W'(head.value);
    assign gmin = WIDE_W'(head.gmin);
    assign gmax = WIDE_W'(head.gmax);
    assign ymin = gmin - sh_min[WIDE_W-1:0];
    assign ymax = gmax + sh_max[WIDE_W-1:0];

    always_comb
    begin
        if (v >= gmin && v <= gmax)
            dev = '0;
        else if (v > ymin && v < gmin)
            dev = gmin - v;
        else if (v > gmax && v < ymax)
            dev = v - gmax;
        else if (v <= ymin)
            dev = v - gmin;
        else if (v >= ymax)
            dev = gmax - v;
        else
            dev = '1;
    end

    assign bit_sel = NUM_CH'(3'b001 << head.ch);

    always_comb
    begin
        yellow_next = yellow_reg;
        red_next    = red_reg;
        armed_next  = armed_reg;
        if (dev == '0)
        begin
            status      = ST_GOOD;
            yellow_next = yellow_reg & ~bit_sel;
            red_next    = red_reg & ~bit_sel;
            armed_next  = armed_reg | bit_sel;
        end
        else if (!dev[WIDE_W-1])
        begin
            status      = ST_YELLOW;
            yellow_next = yellow_reg | bit_sel;
            red_next    = red_reg & ~bit_sel;
            armed_next  = armed_reg | bit_sel;
        end
        else
        begin
            status      = ST_RED;
            yellow_next = yellow_reg & ~bit_sel;
            red_next    = red_reg | bit_sel;
        end

        led_next = (yellow_next != '0) ? !led_reg : 1'b0;

        if (head.button)
            armed_next = armed_next & ~red_next;

        buzzer_next = ((armed_next & red_next) != '0) ? !buzzer_reg : 1'b0;
    end

    assign pop = q_valid && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yellow_reg    <= '0;
            red_reg       <= '0;
            armed_reg     <= '1;
            led_reg       <= 1'b0;
            buzzer_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                yellow_reg <= yellow_next;
                red_reg    <= red_next;
                armed_reg  <= armed_next;
                led_reg    <= led_next;
                buzzer_reg <= buzzer_next;
            end
            if (pop)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_word_reg.ch        <= head.ch;
            out_word_reg.status    <= status;
            out_word_reg.deviation <= dev[DEV_W-1:0];
            out_word_reg.led       <= led_next;
            out_word_reg.buzzer    <= buzzer_next;
            out_word_reg.yellow    <= yellow_next;
            out_word_reg.red       <= red_next;
            out_word_reg.armed     <= armed_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

### rtl/core/three_channel_zone_alarm_monitor.sv
// ----------------------------------------------------------------------------
// Three-channel zone alarm monitor
// Checks one sensor channel per input word in rotation and drives LED,
// buzzer and per-channel alarm flags.
// ----------------------------------------------------------------------------
// Takes one input word per clock and returns one result word per clock while
// the output is not stalled. The front end selects the channel and forms the
// margin products straight into the queue, and the classifier stage pops each
// word and registers the result and the updated flags; it takes a new word
// whenever its output register is empty or being read. The QUEUE_DEPTH-word
// queue absorbs output stalls. After a stall that fills the queue, the input
// resumes in the cycle after the output does. The first word checks the
// humidity channel, then light, temperature, humidity and so on. Band
// registers take effect for words accepted after the write.
`timescale 1ns / 1ps

module three_channel_zone_alarm_monitor
    import tczam_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // temp_value[31:0], hum_value[63:32], light_value[95:64],
    // button_pressed[96], zero pad
    input  logic [103:0]         s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status[1:0], deviation[34:2], led_level[35], buzzer_level[36],
    // yellow_mask[39:37], red_mask[42:40], armed_mask[45:43], zero pad
    output logic [47:0]          m_tdata,
    // channel[1:0]
    output logic [CH_W-1:0]      m_tuser
);

    logic    push, pop, q_full, q_not_empty;
    item_t   push_item, head;
    result_t out_word;

    assign cfg_ready = 1'b1;

    tczam_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .temp_value     (s_tdata[31:0]),
        .hum_value      (s_tdata[63:32]),
        .light_value    (s_tdata[95:64]),
        .button_pressed (s_tdata[96]),
        .queue_full     (q_full),
        .push           (push),
        .push_item      (push_item)
    );

    tczam_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head)
    );

    tczam_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tuser = out_word.ch;
    assign m_tdata = {2'b00, out_word.armed, out_word.red, out_word.yellow,
                      out_word.buzzer, out_word.led, out_word.deviation,
                      out_word.status};

endmodule

### rtl/core/tczam_checker.sv
// ----------------------------------------------------------------------------
// Zone alarm monitor checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "three_channel_zone_alarm_monitor_macros.svh"

module tczam_checker
    import tczam_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            m_tvalid,
    input logic            m_tready,
    input logic [47:0]     m_tdata,
    input logic [CH_W-1:0] m_tuser
);

    logic [1:0]        status;
    logic [NUM_CH-1:0] yellow, red, armed;
    logic              led, buzzer, red_sel;
    logic [CH_W-1:0]   exp_ch_reg;

    assign status  = m_tdata[1:0];
    assign led     = m_tdata[35];
    assign buzzer  = m_tdata[36];
    assign yellow  = m_tdata[39:37];
    assign red     = m_tdata[42:40];
    assign armed   = m_tdata[45:43];
    assign red_sel = |(red & NUM_CH'(3'b001 << m_tuser));

    // channels leave in rotation, starting at humidity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            exp_ch_reg <= CH_HUM;
        else if (m_tvalid && m_tready)
            exp_ch_reg <= (exp_ch_reg == CH_LIGHT) ? CH_TEMP : exp_ch_reg + 2'd1;
    end

    `TCZAM_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output word changed while stalled")
    `TCZAM_ASSERT_OUT(a_ch_rotation, m_tuser == exp_ch_reg, "channel out of rotation")
    `TCZAM_ASSERT_OUT(a_red_flag, (status == ST_RED) == red_sel, "red flag disagrees with status")
    `TCZAM_ASSERT_OUT(a_outputs, (!buzzer || (armed & red) != '0) && (!led || yellow != '0), "LED or buzzer on without alarm")

endmodule

bind three_channel_zone_alarm_monitor tczam_checker u_tczam_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
